[rtl/core/mptt_pkg.sv]
`default_nettype none

package mptt_pkg;

  // field widths of the item and register formats
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned FPS_W    = 10;
  localparam int unsigned SPD_W    = 16;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  // default number of fraction bits in a stored coordinate
  localparam int unsigned FRAC_BITS_DEF = 16;

  // reduced offset keeps 8 fraction bits, so it always spans 25 bits
  localparam int unsigned R_FRAC   = 8;
  localparam int unsigned R_W      = COORD_W + 1 + R_FRAC;
  localparam int unsigned SUM_W    = 2 * R_W;
  localparam int unsigned LEN_W    = SUM_W / 2;
  localparam int unsigned THR_W    = SIZE_W - 1 + R_FRAC;
  localparam int unsigned THR2_W   = 2 * THR_W;

  // unit vector scale and its products
  localparam int unsigned UNIT_SHIFT = 30;
  localparam int unsigned U_W        = UNIT_SHIFT + 1;
  localparam int unsigned P_W        = U_W + SPD_W;

  localparam int unsigned LANES = 2;

  // item opcodes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // register map, selected by paddr[2]
  typedef enum logic {
    REG_MOVE_SPEED  = 1'b0,
    REG_OBJECT_SIZE = 1'b1
  } reg_idx_t;

  localparam logic [SPD_W-1:0]  MOVE_SPEED_RST  = SPD_W'(1);
  localparam logic [SIZE_W-1:0] OBJECT_SIZE_RST = '0;

  typedef struct packed {
    logic                       opcode;
    logic signed [COORD_W-1:0]  target_x;
    logic signed [COORD_W-1:0]  target_y;
    logic        [FPS_W-1:0]    frame_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic                       moved;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sq_en;
    logic tst_en;
    logic sqrt_start;
    logic divu_start;
    logic mul_en;
    logic divs_start;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_set;
    logic pass;
    logic sqrt_done;
    logic divu_done;
    logic divs_done;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/mptt_sqrt.sv]
`default_nettype none

module mptt_sqrt import mptt_pkg::*; #(
  parameter int unsigned IW = SUM_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [IW-1:0]     rad,
  output logic      [IW/2-1:0]   root,
  output logic                   done
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned RW = OW + 2;
  localparam int unsigned CW = $clog2(OW);

  logic [IW-1:0] rad_r;
  logic [OW-1:0] root_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [RW+1:0] cur, trial, diff;
  logic          ge;

  // one root digit per cycle from the top two radicand bits
  assign cur   = {rem_r, rad_r[IW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  // busy and done flags
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= CW'(OW - 1);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      root_r <= {root_r[OW-2:0], ge};
      rem_r  <= ge ? RW'(diff) : RW'(cur);
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

[rtl/core/mptt_div.sv]
`default_nettype none

module mptt_div import mptt_pkg::*; #(
  parameter int unsigned NW = U_W,
  parameter int unsigned DW = LEN_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  input  wire logic [DW-1:0]  rem0,
  output logic      [NW-1:0]  quo,
  output logic                done
);

  localparam int unsigned CW = $clog2(NW);

  // numerator bits leave at the top while quotient bits enter at the bottom
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0]   trial, diff;
  logic          ge;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= rem0;
      den_r <= den;
      cnt_r <= CW'(NW - 1);
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? DW'(diff) : DW'(trial);
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

`default_nettype wire

[rtl/core/mptt_dp.sv]
`default_nettype none

module mptt_dp import mptt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire in_item_t          in_data,
  input  wire logic [SPD_W-1:0]  move_speed,
  input  wire logic [SIZE_W-1:0] object_size,
  output out_item_t              out_data
);

  localparam int unsigned POS_W = COORD_W + FRAC_BITS;
  localparam int unsigned D_W   = POS_W + 1;
  localparam int unsigned E_W   = POS_W + 2;
  localparam int unsigned RSH   = FRAC_BITS - R_FRAC;
  localparam int unsigned SSH   = UNIT_SHIFT - FRAC_BITS;
  localparam int unsigned S_W   = P_W - SSH;

  // per lane state: lane 0 is x, lane 1 is y
  logic signed [POS_W-1:0]  pos_r  [LANES];
  logic signed [POS_W-1:0]  tgt_r  [LANES];
  logic        [R_W-1:0]    r_r    [LANES];
  logic                     neg_r  [LANES];
  logic        [SUM_W-1:0]  sq_r   [LANES];
  logic        [P_W-1:0]    prod_r [LANES];

  logic signed [COORD_W-1:0] tgt_in [LANES];
  logic signed [POS_W-1:0]   tgt_fx [LANES];
  logic signed [POS_W-1:0]   pos_nxt [LANES];
  logic signed [COORD_W-1:0] trunc  [LANES];
  logic        [U_W-1:0]     unit   [LANES];
  logic        [S_W-1:0]     stp    [LANES];
  logic        [LANES-1:0]   divu_done;
  logic        [LANES-1:0]   divs_done;
  logic        [LANES-1:0]   lane_moved;

  // shared item state
  logic                   op_r;
  logic [FPS_W-1:0]       fps_r;
  logic [THR2_W-1:0]      thr2_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   pass_r;
  logic [LEN_W-1:0]       len;
  logic                   sqrt_done;
  logic [THR_W-1:0]       thr;
  logic [SUM_W-1:0]       sum_nxt;
  out_item_t              out_r;

  assign tgt_in[0] = in_data.target_x;
  assign tgt_in[1] = in_data.target_y;

  // arrival threshold in 8 fraction bits
  assign thr     = {object_size[SIZE_W-1:1], {R_FRAC{1'b0}}};
  assign sum_nxt = sq_r[0] + sq_r[1];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [D_W-1:0] d;
    logic        [D_W-1:0] mag;
    logic signed [E_W-1:0] ext, sext, moved_sum;
    logic        [2:0]     top;
    logic signed [POS_W-1:0] sat;
    logic signed [POS_W-1:0] biased;

    // offset to the target and its reduced magnitude
    assign tgt_fx[k] = {tgt_in[k], {FRAC_BITS{1'b0}}};
    assign d         = {tgt_fx[k][POS_W-1], tgt_fx[k]} - {pos_r[k][POS_W-1], pos_r[k]};
    assign mag       = d[D_W-1] ? D_W'(-d) : D_W'(d);

    // step added to the position, clamped to the coordinate range
    assign ext       = {{2{pos_r[k][POS_W-1]}}, pos_r[k]};
    assign sext      = E_W'(stp[k]);
    assign moved_sum = neg_r[k] ? (ext - sext) : (ext + sext);
    assign top       = moved_sum[E_W-1:POS_W-1];
    assign sat       = ((&top) || !(|top)) ? moved_sum[POS_W-1:0] :
                       (moved_sum[E_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                         : {1'b0, {(POS_W-1){1'b1}}});

    assign pos_nxt[k] = (op_r == OP_SET) ? tgt_r[k] : (pass_r ? sat : pos_r[k]);
    assign lane_moved[k] = (pos_nxt[k] != pos_r[k]);

    // truncate toward zero: bias negative values before dropping fraction bits
    assign biased   = pos_nxt[k] + {{COORD_W{1'b0}}, {FRAC_BITS{pos_nxt[k][POS_W-1]}}};
    assign trunc[k] = biased[POS_W-1:FRAC_BITS];

    // unit component, 30 fraction bits
    mptt_div #(
      .NW (U_W),
      .DW (LEN_W)
    ) u_div_unit (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.divu_start),
      .num   ({r_r[k][0], {UNIT_SHIFT{1'b0}}}),
      .den   (len),
      .rem0  (LEN_W'(r_r[k] >> 1)),
      .quo   (unit[k]),
      .done  (divu_done[k])
    );

    // step length, scaled by speed over frame rate
    mptt_div #(
      .NW (S_W),
      .DW (FPS_W)
    ) u_div_step (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.divs_start),
      .num   (S_W'(prod_r[k] >> SSH)),
      .den   (fps_r),
      .rem0  ('0),
      .quo   (stp[k]),
      .done  (divs_done[k])
    );

    // stored position
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[k] <= '0;
      end else if (cmd.commit) begin
        pos_r[k] <= pos_nxt[k];
      end
    end

    // item operands and products
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        tgt_r[k] <= tgt_fx[k];
        r_r[k]   <= R_W'(mag >> RSH);
        neg_r[k] <= d[D_W-1];
      end
      if (cmd.sq_en) begin
        sq_r[k] <= r_r[k] * r_r[k];
      end
      if (cmd.mul_en) begin
        prod_r[k] <= unit[k] * move_speed;
      end
    end
  end

  // length of the reduced offset
  mptt_sqrt #(
    .IW (SUM_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sum_r),
    .root  (len),
    .done  (sqrt_done)
  );

  // shared item registers and move test
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      fps_r <= (in_data.frame_rate == '0) ? FPS_W'(1) : in_data.frame_rate;
    end
    if (cmd.sq_en) begin
      thr2_r <= thr * thr;
    end
    if (cmd.tst_en) begin
      sum_r  <= sum_nxt;
      pass_r <= (sum_nxt > SUM_W'(thr2_r));
    end
    if (cmd.commit) begin
      out_r.pos_x <= trunc[0];
      out_r.pos_y <= trunc[1];
      out_r.moved <= |lane_moved;
    end
  end

  assign sts.is_set    = (op_r == OP_SET);
  assign sts.pass      = pass_r;
  assign sts.sqrt_done = sqrt_done;
  assign sts.divu_done = &divu_done;
  assign sts.divs_done = &divs_done;

  assign out_data = out_r;

endmodule

`default_nettype wire

[rtl/core/mptt_ctrl.sv]
`default_nettype none

module mptt_ctrl import mptt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_CHECK,
    ST_SQRT,
    ST_DIVU,
    ST_KICK,
    ST_DIVS,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // sequencing of one item through the datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sts.is_set) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.sq_en = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd.tst_en = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.pass) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.divu_start = 1'b1;
          state_nxt      = ST_DIVU;
        end
      end
      ST_DIVU: begin
        if (sts.divu_done) begin
          cmd.mul_en = 1'b1;
          state_nxt  = ST_KICK;
        end
      end
      ST_KICK: begin
        cmd.divs_start = 1'b1;
        state_nxt      = ST_DIVS;
      end
      ST_DIVS: begin
        if (sts.divs_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/core/move_point_toward_target_core.sv]
`default_nettype none

// Seeks a 2D point toward a target at constant speed, one item at a time.
// Input channel (in_valid/in_ready/in_data): a step item moves the position
// toward the target by move_speed/frame_rate when the target is farther than
// half of object_size; a set item loads the target as the position.
// Result channel (out_valid/out_ready/out_data): one beat per item with the
// position truncated toward zero and a moved flag.
// A set item goes straight to commit, and a step that stays put only runs the
// distance test. A step that moves runs the square root, the unit-vector
// divider and the speed/frame-rate divider back to back.
// The next item is taken in the cycle after the previous result is loaded.
// The result sits in an output register; when the receiver stalls, one
// finished result waits there and the next item holds at its final commit.
// Reset (rst_n low, synchronous) clears the position to zero, sets
// move_speed to 1 and object_size to 0, and drops out_valid.
// Configuration must be written over the APB-style port only while idle; the block does not enforce this.

module move_point_toward_target_core import mptt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [SPD_W-1:0]  move_speed_r, move_speed_nxt;
  logic [SIZE_W-1:0] object_size_r, object_size_nxt;
  reg_idx_t          reg_sel;
  logic              wr_en;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // register write and read decode
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    move_speed_nxt  = move_speed_r;
    object_size_nxt = object_size_r;
    prdata          = '0;
    case (reg_sel)
      REG_MOVE_SPEED: begin
        prdata = DATA_W'(move_speed_r);
        if (wr_en) begin
          move_speed_nxt = pwdata[SPD_W-1:0];
        end
      end
      REG_OBJECT_SIZE: begin
        prdata = DATA_W'(object_size_r);
        if (wr_en) begin
          object_size_nxt = pwdata[SIZE_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= MOVE_SPEED_RST;
      object_size_r <= OBJECT_SIZE_RST;
    end else begin
      move_speed_r  <= move_speed_nxt;
      object_size_r <= object_size_nxt;
    end
  end

  mptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mptt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .move_speed  (move_speed_r),
    .object_size (object_size_r),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

[rtl/core/mptt_checker.sv]
`default_nettype none

module mptt_checker import mptt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // one item in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed or dropped under stall");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not empty after reset");

  // a set item accepted with a free output returns its target as the result
  a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.opcode == OP_SET) && !out_valid) |->
      ##3 (out_valid && (out_data.pos_x == $past(in_data.target_x, 3)) &&
           (out_data.pos_y == $past(in_data.target_y, 3))))
    else $error("set item result wrong or late");

endmodule

bind move_point_toward_target_core mptt_checker u_mptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb import mptt_pkg::*; ();

  localparam int unsigned FRAC     = FRAC_BITS_DEF;
  localparam int unsigned LIMIT    = 500000;
  localparam int unsigned SETTLE   = 120;
  localparam int unsigned IDLE_PCT = 17;

  // predicted position, register copies and expected result beats
  class seek_scoreboard;
    longint          pos_x;
    longint          pos_y;
    int unsigned     speed_reg;
    int unsigned     size_reg;
    out_item_t       due_positions[$];
    int unsigned     errors;

    function new();
      pos_x     = 0;
      pos_y     = 0;
      speed_reg = 1;
      size_reg  = 0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
      if (idx == REG_MOVE_SPEED) begin
        speed_reg = 32'(val[SPD_W-1:0]);
      end else begin
        size_reg = 32'(val[SIZE_W-1:0]);
      end
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // integer part, rounded toward zero
    function logic [COORD_W-1:0] coord_out(longint p);
      longint q;
      if (p < 0) begin
        q = -longint'(magnitude(p) >> FRAC);
      end else begin
        q = p >>> FRAC;
      end
      return q[COORD_W-1:0];
    endfunction

    function longint saturate(longint p);
      longint lo;
      longint hi;
      lo = -(longint'(32768) << FRAC);
      hi = (longint'(32768) << FRAC) - 1;
      if (p < lo) return lo;
      if (p > hi) return hi;
      return p;
    endfunction

    // floor square root, one result bit per pass
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 26; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // one axis of the step: unit component scaled by speed / frame rate
    function longint stride(longint unsigned rmag, bit neg, longint unsigned len,
                            longint unsigned rate);
      longint unsigned unit;
      longint unsigned s;
      unit = (rmag << UNIT_SHIFT) / len;
      s = ((unit * longint'(speed_reg)) / rate) >> (UNIT_SHIFT - FRAC);
      return neg ? -longint'(s) : longint'(s);
    endfunction

    // accepted input beat: advance the position and queue the result
    function void note_item(in_item_t item);
      longint          tx, ty, dx, dy, nx, ny;
      longint unsigned rx, ry, sum, thr, len, rate;
      out_item_t       res;
      tx   = longint'($signed(item.target_x)) <<< FRAC;
      ty   = longint'($signed(item.target_y)) <<< FRAC;
      rate = 64'(item.frame_rate);
      if (rate == 0) rate = 1;
      nx = pos_x;
      ny = pos_y;
      if (item.opcode == OP_SET) begin
        nx = saturate(tx);
        ny = saturate(ty);
      end else begin
        dx  = tx - pos_x;
        dy  = ty - pos_y;
        rx  = magnitude(dx) >> (FRAC - R_FRAC);
        ry  = magnitude(dy) >> (FRAC - R_FRAC);
        sum = rx * rx + ry * ry;
        thr = longint'(size_reg >> 1) << R_FRAC;
        if (sum > thr * thr) begin
          len = root_floor(sum);
          nx  = saturate(pos_x + stride(rx, dx < 0, len, rate));
          ny  = saturate(pos_y + stride(ry, dy < 0, len, rate));
        end
      end
      res.moved = (nx != pos_x) || (ny != pos_y);
      pos_x     = nx;
      pos_y     = ny;
      res.pos_x = coord_out(nx);
      res.pos_y = coord_out(ny);
      due_positions.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_positions.size() == 0) begin
        $error("result beat with nothing expected: pos_x %0d pos_y %0d moved %0b",
               got.pos_x, got.pos_y, got.moved);
        errors++;
        return;
      end
      want = due_positions.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
        errors++;
      end
      if (got.moved !== want.moved) begin
        $error("moved: expected %0b, got %0b", want.moved, got.moved);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  seek_scoreboard    sb = new();
  bit                steady;
  int unsigned       cycles = 0;
  logic signed [COORD_W-1:0] aim_x;
  logic signed [COORD_W-1:0] aim_y;

  move_point_toward_target_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls at random outside the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  function automatic in_item_t make_item(logic op, int x, int y, int unsigned rate);
    in_item_t item;
    item.opcode     = op;
    item.target_x   = COORD_W'(x);
    item.target_y   = COORD_W'(y);
    item.frame_rate = FPS_W'(rate);
    return item;
  endfunction

  function automatic int clip_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly seek runs toward a held or nearby target, some fresh random points
  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned pick;
    int          span;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // keep seeking the same target
    end else if (pick < 70) begin
      span  = int'(sb.size_reg >> 1) + 40;
      aim_x = COORD_W'(clip_coord(int'($signed(sb.coord_out(sb.pos_x)))
                                  + int'($urandom_range(2 * span)) - span));
      aim_y = COORD_W'(clip_coord(int'($signed(sb.coord_out(sb.pos_y)))
                                  + int'($urandom_range(2 * span)) - span));
    end else begin
      aim_x = COORD_W'($urandom);
      aim_y = COORD_W'($urandom);
    end
    item.opcode   = ($urandom_range(99) < 15) ? OP_SET : OP_STEP;
    item.target_x = aim_x;
    item.target_y = aim_y;
    case ($urandom_range(19))
      0: begin
        item.frame_rate = '0;
      end
      1: begin
        item.frame_rate = FPS_W'(1);
      end
      2: begin
        item.frame_rate = '1;
      end
      default: begin
        item.frame_rate = FPS_W'($urandom_range(1023, 1));
      end
    endcase
    return item;
  endfunction

  // one input beat, with random idle cycles ahead of it outside the steady stretch
  task automatic send_item(input in_item_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_item(item);
  endtask

  // hold the sender until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_positions.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input int unsigned spd, input int unsigned sz);
    drain();
    write_reg(REG_MOVE_SPEED, DATA_W'(spd));
    write_reg(REG_OBJECT_SIZE, DATA_W'(sz));
  endtask

  task automatic run_phase(input int unsigned spd, input int unsigned sz,
                           input int unsigned count);
    configure(spd, sz);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send_item(random_item());
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    steady    = 1'b0;
    aim_x     = '0;
    aim_y     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fast seek: overshoot into saturation, zero and top frame rates
    configure(65535, 0);
    send_item(make_item(OP_SET, 0, 0, 5));
    send_item(make_item(OP_STEP, 32767, 0, 1));
    send_item(make_item(OP_SET, 0, 0, 0));
    send_item(make_item(OP_STEP, -32768, 0, 0));
    send_item(make_item(OP_SET, -32768, -32768, 1023));
    send_item(make_item(OP_STEP, 32767, 32767, 1));
    send_item(make_item(OP_SET, 32767, 32767, 1));
    send_item(make_item(OP_STEP, -32768, -32768, 1023));

    // arrival threshold, sitting on the target, unchanged set
    configure(300, 10);
    send_item(make_item(OP_SET, 5, 5, 60));
    send_item(make_item(OP_STEP, 5, 5, 60));
    send_item(make_item(OP_STEP, 8, 5, 60));
    send_item(make_item(OP_STEP, 100, -100, 1023));
    send_item(make_item(OP_SET, 100, -100, 1));
    send_item(make_item(OP_SET, 100, -100, 512));
    send_item(make_item(OP_STEP, -32768, 32767, 60));
    send_item(make_item(OP_STEP, -32768, 32767, 1));

    // zero speed: test passes but no step item moves
    configure(0, 0);
    send_item(make_item(OP_STEP, 1000, 1000, 1));
    send_item(make_item(OP_SET, -1, -1, 0));
    send_item(make_item(OP_STEP, 1, 1, 1023));
    send_item(make_item(OP_STEP, -1, -1, 7));

    // random seek runs over several register settings
    run_phase(1, 0, 60);
    run_phase(0, 0, 40);
    run_phase(65535, 65535, 60);
    run_phase(65535, 0, 60);
    steady = 1'b1;
    run_phase(2000, 40, 90);
    steady = 1'b0;
    run_phase($urandom_range(65535), $urandom_range(65535), 60);
    run_phase($urandom_range(4000), $urandom_range(200), 70);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.due_positions.size() != 0) begin
      $error("%0d result beats never arrived", sb.due_positions.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
